// ===== src/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Types and codes used by the interrupt controller.
// ----------------------------------------------------------------------------
package pic_pkg;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_EVENT = 2'd2;
	localparam logic [1:0] REQ_RSVD  = 2'd3;

	typedef enum logic [2:0] {
		K_NONE,
		K_BAD,
		K_PRIO,
		K_PEND,
		K_EN,
		K_THR,
		K_CLAIM,
		K_EVENT
	} kind_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [25:0] bus_offset;
		logic [31:0] write_data;
		logic [4:0]  event_source;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [3:0]  irq_lines;
		logic        bad_access;
	} rsp_t;

endpackage

// ===== src/platform_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// platform_interrupt_controller
// Platform-level interrupt controller behind a 32-bit register port.
// ----------------------------------------------------------------------------
// A request (bus read, bus write or source event) is a transfer on req,
// taken when start is high and busy is low. busy stays high until the
// result has been shown: done is high for one cycle with rsp holding the
// read data, the per-context irq lines and the bad access flag. The
// receiver cannot stall; it must take rsp in the cycle of done.
// Source priorities live in a RAM with a registered read port. After every
// request the controller scans all sources, one priority read a cycle,
// and updates the best candidate of every context in parallel; that scan
// sets the latency. A priority read first fetches its entry in a state of
// its own, and a claim read scans twice: once to pick the source and
// again for the lines.
// One request is in flight at a time.
// Reset clears the control registers at once but not the RAM; priority
// entries carry valid bits, so unwritten ones read zero, with no clearing pass.
// ----------------------------------------------------------------------------
module platform_interrupt_controller #(
	parameter int NUM_SOURCES  = 32,
	parameter int NUM_CONTEXTS = 4,
	parameter int PRIO_BITS    = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pic_pkg::req_t req,
	output logic          done,
	output pic_pkg::rsp_t rsp
);

	localparam int NW = (NUM_SOURCES + 31) / 32;
	localparam int NB = NW * 32;
	localparam int IW = $clog2(NUM_SOURCES);
	localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int WW = (NW > 1) ? $clog2(NW) : 1;
	localparam int NL = (NUM_CONTEXTS < 4) ? NUM_CONTEXTS : 4;
	localparam logic [25:0] PRIO_END = 26'(4 * NUM_SOURCES);
	localparam logic [25:0] PEND_BASE = 26'h1000;
	localparam logic [25:0] PEND_END = 26'(32'h1000 + 4 * NW);
	localparam logic [25:0] EN_BASE = 26'h2000;
	localparam logic [25:0] EN_END = 26'(32'h2000 + 32'h80 * NUM_CONTEXTS);
	localparam logic [25:0] CTX_BASE = 26'h200000;
	localparam logic [25:0] CTX_END = 26'(32'h200000 + 32'h1000 * NUM_CONTEXTS);

	function automatic logic [NB-1:0] src_mask();
		logic [NB-1:0] m;
		for (int i = 0; i < NB; i++) begin
			m[i] = (i != 0) && (i < NUM_SOURCES);
		end
		return m;
	endfunction

	localparam logic [NB-1:0] SRC_MASK = src_mask();

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_OP    = 6'b000010,
		ST_PRD   = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_CLAIM = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	pic_pkg::kind_t kind_q, kind_d;
	logic wr_q;
	logic [31:0] data_q;
	logic [25:0] off_q;
	logic [CW-1:0] ctx_q, ctx_d;
	logic [4:0] word_q, word_d;
	logic [4:0] src_q;
	logic [31:0] rd_q;
	logic bad_q;
	logic pre_q;

	logic [NUM_SOURCES-1:0] prio_vld_q;
	logic [NB-1:0] pend_q, insvc_q;
	logic [NUM_CONTEXTS-1:0][NB-1:0] en_q;
	logic [NUM_CONTEXTS-1:0][PRIO_BITS-1:0] thr_q, bp_q;
	logic [NUM_CONTEXTS-1:0][IW-1:0] best_q;

	logic issue_q, v_s1, last_s1;
	logic [IW-1:0] scan_q, id_s1;

	logic ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [PRIO_BITS-1:0] ram_wdata, ram_rdata;

	logic [25:0] rel_en, rel_ctx;
	logic [3:0] lines;

	assign rel_en = req.bus_offset - EN_BASE;
	assign rel_ctx = req.bus_offset - CTX_BASE;

	always_comb begin
		kind_d = pic_pkg::K_NONE;
		ctx_d = '0;
		word_d = '0;
		if (req.req_type == pic_pkg::REQ_EVENT) begin
			kind_d = pic_pkg::K_EVENT;
		end else if (req.req_type == pic_pkg::REQ_READ || req.req_type == pic_pkg::REQ_WRITE) begin
			kind_d = pic_pkg::K_BAD;
			if (req.bus_offset[1:0] != 2'b00) begin
				kind_d = pic_pkg::K_BAD;
			end else if (req.bus_offset < PRIO_END) begin
				kind_d = pic_pkg::K_PRIO;
			end else if (req.bus_offset >= PEND_BASE && req.bus_offset < PEND_END) begin
				kind_d = pic_pkg::K_PEND;
				word_d = req.bus_offset[6:2];
			end else if (req.bus_offset >= EN_BASE && req.bus_offset < EN_END) begin
				ctx_d = rel_en[7 +: CW];
				word_d = rel_en[6:2];
				if (32'(rel_en[6:2]) < NW) begin
					kind_d = pic_pkg::K_EN;
				end
			end else if (req.bus_offset >= CTX_BASE && req.bus_offset < CTX_END) begin
				ctx_d = rel_ctx[12 +: CW];
				if (rel_ctx[11:0] == 12'h000) begin
					kind_d = pic_pkg::K_THR;
				end else if (rel_ctx[11:0] == 12'h004) begin
					kind_d = pic_pkg::K_CLAIM;
				end
			end
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = off_q[IW+1:2];
		ram_wdata = data_q[PRIO_BITS-1:0];
		ram_raddr = issue_q ? scan_q : off_q[IW+1:2];
		if (state_q == ST_OP && kind_q == pic_pkg::K_PRIO && wr_q && off_q[IW+1:2] != '0) begin
			ram_we = 1'b1;
		end
	end

	pic_ram #(
		.WIDTH(PRIO_BITS),
		.DEPTH(NUM_SOURCES)
	) u_prio_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prio_vld_q <= '0;
			pend_q <= '0;
			insvc_q <= '0;
			en_q <= '0;
			thr_q <= '0;
			issue_q <= 1'b0;
			v_s1 <= 1'b0;
			pre_q <= 1'b0;
		end else begin
			v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q <= kind_d;
						wr_q <= (req.req_type == pic_pkg::REQ_WRITE);
						data_q <= req.write_data;
						off_q <= req.bus_offset;
						ctx_q <= ctx_d;
						word_q <= word_d;
						src_q <= req.event_source;
						rd_q <= '0;
						bad_q <= (kind_d == pic_pkg::K_BAD);
						state_q <= ST_OP;
					end
				end
				ST_OP: begin
					state_q <= ST_SCAN;
					issue_q <= 1'b1;
					pre_q <= 1'b0;
					unique case (kind_q)
						pic_pkg::K_PRIO: begin
							if (wr_q) begin
								if (off_q[IW+1:2] != '0) begin
									prio_vld_q[off_q[IW+1:2]] <= 1'b1;
								end
							end else begin
								state_q <= ST_PRD;
								issue_q <= 1'b0;
							end
						end
						pic_pkg::K_PEND: begin
							if (!wr_q) begin
								rd_q <= pend_q[32*int'(word_q[WW-1:0]) +: 32];
							end
						end
						pic_pkg::K_EN: begin
							if (wr_q) begin
								en_q[ctx_q][32*int'(word_q[WW-1:0]) +: 32] <= data_q &
									SRC_MASK[32*int'(word_q[WW-1:0]) +: 32];
							end else begin
								rd_q <= en_q[ctx_q][32*int'(word_q[WW-1:0]) +: 32];
							end
						end
						pic_pkg::K_THR: begin
							if (wr_q) begin
								thr_q[ctx_q] <= data_q[PRIO_BITS-1:0];
							end else begin
								rd_q <= 32'(thr_q[ctx_q]);
							end
						end
						pic_pkg::K_CLAIM: begin
							if (wr_q) begin
								if (data_q != '0 && data_q < 32'(NUM_SOURCES) &&
									en_q[ctx_q][data_q[IW-1:0]]) begin
									insvc_q[data_q[IW-1:0]] <= 1'b0;
								end
							end else begin
								pre_q <= 1'b1;
							end
						end
						pic_pkg::K_EVENT: begin
							if (src_q != '0 && 32'(src_q) < 32'(NUM_SOURCES) &&
								!insvc_q[32'(src_q)]) begin
								pend_q[32'(src_q)] <= 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				ST_PRD: begin
					rd_q <= prio_vld_q[off_q[IW+1:2]] ? 32'(ram_rdata) : '0;
					issue_q <= 1'b1;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (v_s1 && last_s1) begin
						state_q <= pre_q ? ST_CLAIM : ST_OUT;
					end
				end
				ST_CLAIM: begin
					if (best_q[ctx_q] != '0) begin
						pend_q[best_q[ctx_q]] <= 1'b0;
						insvc_q[best_q[ctx_q]] <= 1'b1;
					end
					rd_q <= 32'(best_q[ctx_q]);
					pre_q <= 1'b0;
					issue_q <= 1'b1;
					state_q <= ST_SCAN;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (issue_q) begin
				v_s1 <= 1'b1;
				if (scan_q == IW'(NUM_SOURCES - 1)) begin
					issue_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!issue_q && !v_s1) begin
			scan_q <= IW'(1);
			bp_q <= thr_q;
			best_q <= '0;
		end else begin
			if (issue_q) begin
				scan_q <= scan_q + IW'(1);
				id_s1 <= scan_q;
				last_s1 <= (scan_q == IW'(NUM_SOURCES - 1));
				if (scan_q == IW'(1)) begin
					bp_q <= thr_q;
				end
			end
			if (v_s1) begin
				for (int c = 0; c < NUM_CONTEXTS; c++) begin
					if (pend_q[id_s1] && en_q[c][id_s1] && prio_vld_q[id_s1] &&
						ram_rdata > bp_q[c]) begin
						bp_q[c] <= ram_rdata;
						best_q[c] <= id_s1;
					end
				end
			end
		end
	end

	always_comb begin
		lines = '0;
		for (int c = 0; c < NL; c++) begin
			lines[c] = (best_q[c] != '0);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_OUT);
	assign rsp.read_data = rd_q;
	assign rsp.irq_lines = lines;
	assign rsp.bad_access = bad_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe outside a request");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("controller did not return to idle after the result");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not start work");
	a_scan_issue: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> (state_q == ST_SCAN))
		else $error("priority scan running outside the scan state");

endmodule

// ===== src/pic_ram.sv =====
// ----------------------------------------------------------------------------
// pic_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module pic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
